@@ src/sca_pkg.sv @@
// Shared constants, types and codes of the slab chunk allocator.
package sca_pkg;

    localparam int PAGE_BYTES          = 65536;
    localparam int POOL_PAGES          = 64;
    localparam int CLASSES             = 32;
    localparam int CHUNKS_PER_PAGE_MAX = 1024;
    localparam int ALIGN_BYTES         = 8;

    localparam int PAGE_W   = $clog2(PAGE_BYTES);
    localparam int SIZE_W   = PAGE_W + 1;
    localparam int PG_W     = $clog2(POOL_PAGES);
    localparam int PGC_W    = $clog2(POOL_PAGES + 1);
    localparam int IDX_W    = $clog2(CHUNKS_PER_PAGE_MAX);
    localparam int PER_W    = $clog2(CHUNKS_PER_PAGE_MAX + 1);
    localparam int ID_W     = PG_W + IDX_W;
    localparam int CLS_W    = 5;
    localparam int CNT_W    = 17;
    localparam int ADDR_W   = 22;
    localparam int REQ_W    = 17;
    localparam int HDR_W    = 9;
    localparam int PAY_W    = 13;
    localparam int GF_W     = 11;
    localparam int TOT_W    = REQ_W + 1;
    localparam int RS_W     = SIZE_W + GF_W - 8;
    localparam int PROD_W   = RS_W + GF_W;
    localparam int USED_W   = 11;
    localparam int CFG_W    = 13;
    localparam int CFGI_W   = 2;
    localparam int DIV_W    = SIZE_W;
    localparam int ALIGN_W  = $clog2(ALIGN_BYTES);

    localparam logic [CFGI_W-1:0] CFG_CHUNK_PAYLOAD = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_HEADER        = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_GROWTH        = 2'd2;

    localparam logic [PAY_W-1:0] PAYLOAD_RESET = 13'd48;
    localparam logic [HDR_W-1:0] HEADER_RESET  = 9'd16;
    localparam logic [GF_W-1:0]  GROWTH_RESET  = 11'd320;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_CLASS  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_RB_INIT, S_RB_MUL, S_RB_CMP, S_RB_DIV, S_RB_END,
        S_IDLE, S_SRCH,
        S_A_SEL, S_A_POP, S_A_STK, S_A_CLAIM, S_A_CARVE,
        S_A_USE_RD, S_A_USE_WR, S_A_ADDR,
        S_F_CHK0, S_F_DIV, S_F_CHK1, S_F_PUSH,
        S_P_INIT, S_P_RD, S_P_ST, S_P_END,
        S_FIN
    } t_state;

    typedef struct packed {
        t_state step;
        logic   accept;
        logic   div_start;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic cfg_write;
        logic rb_stop;
        logic div_done;
        logic hit;
        logic miss;
        logic is_free;
        logic cnt_nz;
        logic cur_valid;
        logic stk_nz;
        logic fresh_ok;
        logic addr_low;
        logic free_bad;
        logic page_empty;
        logic walk_last;
        logic out_busy;
    } t_sts;

endpackage

@@ src/slab_chunk_allocator.sv @@
// Top level of the slab chunk allocator.
//
// Input channel (i_valid / o_stall) carries one request: i_kind 0 allocates a
// chunk for i_request_bytes, i_kind 1 frees the chunk at i_user_address. The
// output channel (o_valid / i_stall) returns one result per request: status,
// payload address, class index and a page-released flag.
// One request is worked at a time; the next can be taken in the cycle after the
// result is loaded. The class search tries the classes in order, up to 32. An
// allocate pops its free list, carves its current page, opens a fresh page or
// reuses a released page. A free runs the 17-step serial divider; a free that
// empties a page also walks the free list of its class (the purge walk).
// After reset, and after any register write, the class table is rebuilt
// (one divider pass per class), with o_stall high.
// The result sits in an output register: a new request is taken while it
// waits; a finished result waits in the controller while the receiver stalls.
// Register writes are taken at any cycle the write enable is high.
module slab_chunk_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_kind,
    input  logic [sca_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [sca_pkg::ADDR_W-1:0]  i_user_address,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [sca_pkg::ADDR_W-1:0]  o_result_address,
    output logic [sca_pkg::CLS_W-1:0]   o_class_index,
    output logic                        o_page_released,
    input  logic                        i_cfg_we,
    input  logic [sca_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [sca_pkg::CFG_W-1:0]   i_cfg_data
);
    sca_pkg::t_cmd cmd;
    sca_pkg::t_sts sts;

    sca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    sca_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_request_bytes  (i_request_bytes),
        .i_user_address   (i_user_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_class_index    (o_class_index),
        .o_page_released  (o_page_released)
    );

endmodule

@@ src/sca_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module sca_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [sca_pkg::DIV_W-1:0] i_dividend,
    input  logic [sca_pkg::DIV_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [sca_pkg::DIV_W-1:0] o_quot,
    output logic [sca_pkg::DIV_W-1:0] o_rem
);
    localparam int W   = sca_pkg::DIV_W;
    localparam int CTW = $clog2(W + 1);

    logic           r_busy, r_done;
    logic [CTW-1:0] r_cnt;
    logic [W-1:0]   r_q, r_r, r_d;
    logic [W:0]     shifted, diff;

    assign shifted = {r_r, r_q[W-1]};
    assign diff    = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CTW'(1);
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_r <= diff[W-1:0];
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_r <= shifted[W-1:0];
                r_q <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

@@ src/sca_ctrl.sv @@
// Sequencer of the allocator: rebuild, class search, alloc, free and purge steps.
module sca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sca_pkg::t_sts i_sts,
    output logic          o_stall,
    output sca_pkg::t_cmd o_cmd
);
    sca_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sca_pkg::S_RB_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.step      = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            sca_pkg::S_RB_INIT: n_state = sca_pkg::S_RB_MUL;
            sca_pkg::S_RB_MUL:  n_state = sca_pkg::S_RB_CMP;
            sca_pkg::S_RB_CMP: begin
                if (i_sts.rb_stop) begin
                    n_state = sca_pkg::S_RB_END;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = sca_pkg::S_RB_DIV;
                end
            end
            sca_pkg::S_RB_DIV: if (i_sts.div_done) n_state = sca_pkg::S_RB_MUL;
            sca_pkg::S_RB_END: n_state = sca_pkg::S_IDLE;
            sca_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = sca_pkg::S_SRCH;
                end
            end
            sca_pkg::S_SRCH: begin
                if (i_sts.hit) begin
                    n_state = i_sts.is_free ? sca_pkg::S_F_CHK0 : sca_pkg::S_A_SEL;
                end else if (i_sts.miss) begin
                    n_state = sca_pkg::S_FIN;
                end
            end
            sca_pkg::S_A_SEL: begin
                priority if (i_sts.cnt_nz)    n_state = sca_pkg::S_A_POP;
                else if (i_sts.cur_valid)     n_state = sca_pkg::S_A_CARVE;
                else if (i_sts.stk_nz)        n_state = sca_pkg::S_A_STK;
                else if (i_sts.fresh_ok)      n_state = sca_pkg::S_A_CLAIM;
                else                          n_state = sca_pkg::S_FIN;
            end
            sca_pkg::S_A_POP:    n_state = sca_pkg::S_A_USE_RD;
            sca_pkg::S_A_STK:    n_state = sca_pkg::S_A_CLAIM;
            sca_pkg::S_A_CLAIM:  n_state = sca_pkg::S_A_CARVE;
            sca_pkg::S_A_CARVE:  n_state = sca_pkg::S_A_USE_RD;
            sca_pkg::S_A_USE_RD: n_state = sca_pkg::S_A_USE_WR;
            sca_pkg::S_A_USE_WR: n_state = sca_pkg::S_A_ADDR;
            sca_pkg::S_A_ADDR:   n_state = sca_pkg::S_FIN;
            sca_pkg::S_F_CHK0: begin
                if (i_sts.addr_low) begin
                    n_state = sca_pkg::S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = sca_pkg::S_F_DIV;
                end
            end
            sca_pkg::S_F_DIV:  if (i_sts.div_done) n_state = sca_pkg::S_F_CHK1;
            sca_pkg::S_F_CHK1: n_state = i_sts.free_bad ? sca_pkg::S_FIN : sca_pkg::S_F_PUSH;
            sca_pkg::S_F_PUSH: n_state = i_sts.page_empty ? sca_pkg::S_P_INIT : sca_pkg::S_FIN;
            sca_pkg::S_P_INIT: n_state = sca_pkg::S_P_RD;
            sca_pkg::S_P_RD:   n_state = sca_pkg::S_P_ST;
            sca_pkg::S_P_ST:   n_state = i_sts.walk_last ? sca_pkg::S_P_END : sca_pkg::S_P_RD;
            sca_pkg::S_P_END:  n_state = sca_pkg::S_FIN;
            sca_pkg::S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sca_pkg::S_IDLE;
                end
            end
            default: n_state = sca_pkg::S_RB_INIT;
        endcase
        // a register write restarts the table build from any state
        if (i_sts.cfg_write) begin
            n_state = sca_pkg::S_RB_INIT;
        end
    end

    assign o_stall = (r_state != sca_pkg::S_IDLE);

endmodule

@@ src/sca_dp.sv @@
// Datapath: class table, free lists, page bookkeeping, link and stack memories.
module sca_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sca_pkg::t_cmd               i_cmd,
    output sca_pkg::t_sts               o_sts,
    input  logic                        i_kind,
    input  logic [sca_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [sca_pkg::ADDR_W-1:0]  i_user_address,
    input  logic                        i_cfg_we,
    input  logic [sca_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [sca_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [sca_pkg::ADDR_W-1:0]  o_result_address,
    output logic [sca_pkg::CLS_W-1:0]   o_class_index,
    output logic                        o_page_released
);
    localparam int NC  = sca_pkg::CLASSES;
    localparam int NP  = sca_pkg::POOL_PAGES;
    localparam int PGW = sca_pkg::PG_W;

    // configuration
    logic [sca_pkg::PAY_W-1:0] r_pay;
    logic [sca_pkg::HDR_W-1:0] r_hdr;
    logic [sca_pkg::GF_W-1:0]  r_gf;

    // class table
    logic [sca_pkg::SIZE_W-1:0] r_size_tab [NC];
    logic [sca_pkg::PER_W-1:0]  r_per_tab  [NC];
    logic [sca_pkg::CLS_W-1:0]  r_largest;

    // per-class list and current page
    logic [sca_pkg::ID_W-1:0]  r_head  [NC];
    logic [sca_pkg::CNT_W-1:0] r_cnt   [NC];
    logic                      r_cvalid[NC];
    logic [PGW-1:0]            r_cpage [NC];
    logic [sca_pkg::PER_W-1:0] r_cnext [NC];
    logic [sca_pkg::PER_W-1:0] r_cleft [NC];

    // page state: owned bits in flops, owner and used count in memory
    logic                      r_owned [NP];
    logic [sca_pkg::CLS_W+sca_pkg::USED_W-1:0] pg_mem [NP];
    logic [sca_pkg::CLS_W+sca_pkg::USED_W-1:0] r_pg_rd;
    logic [PGW-1:0]            stk_mem [NP];
    logic [PGW-1:0]            r_stk_rd;
    logic [sca_pkg::ID_W-1:0]  link_mem [2**sca_pkg::ID_W];
    logic [sca_pkg::ID_W-1:0]  r_link_rd;
    logic [sca_pkg::PGC_W-1:0] r_top, r_fresh;

    // working registers
    logic                        r_kind;
    logic [sca_pkg::REQ_W-1:0]   r_req;
    logic [sca_pkg::ADDR_W-1:0]  r_uaddr;
    logic [sca_pkg::CLS_W-1:0]   r_cls, r_i;
    logic [sca_pkg::RS_W-1:0]    r_size;
    logic [sca_pkg::PROD_W-1:0]  r_rbprod;
    logic [PGW-1:0]              r_page, r_np;
    logic                        r_oob;
    logic [sca_pkg::IDX_W-1:0]   r_idx;
    logic [sca_pkg::IDX_W+sca_pkg::SIZE_W-1:0] r_aprod;
    logic [sca_pkg::ID_W-1:0]    r_cur, r_prev, r_new_head;
    logic                        r_have_prev;
    logic [sca_pkg::CNT_W-1:0]   r_k, r_n, r_kept;
    logic [1:0]                  r_status;
    logic [sca_pkg::ADDR_W-1:0]  r_addr;
    logic                        r_rel;

    // combinational
    logic [sca_pkg::TOT_W-1:0]  total;
    logic [sca_pkg::SIZE_W-1:0] sz_c;
    logic [sca_pkg::RS_W:0]     a_sum, a_al;
    logic [sca_pkg::ADDR_W-1:0] ua_off;
    logic [sca_pkg::ADDR_W-sca_pkg::PAGE_W-1:0] ua_page;
    logic [sca_pkg::SIZE_W+sca_pkg::GF_W-1:0] next_size;
    logic [sca_pkg::CLS_W-1:0]  pg_owner;
    logic [sca_pkg::USED_W-1:0] pg_used, used_dec;
    logic [sca_pkg::PER_W-1:0]  left_dec;
    logic                       div_done;
    logic [sca_pkg::DIV_W-1:0]  div_a, div_b, div_q, div_r;
    logic [sca_pkg::ID_W-1:0]   link_ra, link_wa, link_wd;
    logic                       link_we;
    logic [PGW-1:0]             pg_wa;
    logic [sca_pkg::CLS_W+sca_pkg::USED_W-1:0] pg_wd;
    logic                       pg_we;
    logic [PGW-1:0]             stk_ra;
    logic                       cfg_hit;

    assign total     = {1'b0, r_req} + sca_pkg::TOT_W'(r_hdr);
    assign sz_c      = r_size_tab[r_cls];
    assign a_sum     = {1'b0, r_size} + (sca_pkg::RS_W+1)'(sca_pkg::ALIGN_BYTES - 1);
    assign a_al      = ({a_sum[sca_pkg::RS_W:sca_pkg::ALIGN_W], sca_pkg::ALIGN_W'(0)} == '0) ?
                       (sca_pkg::RS_W+1)'(sca_pkg::ALIGN_BYTES) :
                       {a_sum[sca_pkg::RS_W:sca_pkg::ALIGN_W], sca_pkg::ALIGN_W'(0)};
    assign next_size = a_al[sca_pkg::SIZE_W-1:0] * r_gf;
    assign ua_off    = r_uaddr - sca_pkg::ADDR_W'(r_hdr);
    assign ua_page   = ua_off[sca_pkg::ADDR_W-1:sca_pkg::PAGE_W];
    assign pg_owner  = r_pg_rd[sca_pkg::CLS_W+sca_pkg::USED_W-1:sca_pkg::USED_W];
    assign pg_used   = r_pg_rd[sca_pkg::USED_W-1:0];
    assign used_dec  = (pg_used != '0) ? pg_used - sca_pkg::USED_W'(1) : '0;
    assign left_dec  = (r_cleft[r_cls] != '0) ? r_cleft[r_cls] - sca_pkg::PER_W'(1) : '0;
    assign cfg_hit   = i_cfg_we && (i_cfg_index == sca_pkg::CFG_CHUNK_PAYLOAD ||
                       i_cfg_index == sca_pkg::CFG_HEADER ||
                       i_cfg_index == sca_pkg::CFG_GROWTH);

    assign div_a = (i_cmd.step == sca_pkg::S_RB_CMP) ? sca_pkg::DIV_W'(sca_pkg::PAGE_BYTES) :
                   sca_pkg::DIV_W'(ua_off[sca_pkg::PAGE_W-1:0]);
    assign div_b = (i_cmd.step == sca_pkg::S_RB_CMP) ? a_al[sca_pkg::DIV_W-1:0] : sz_c;

    sca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // status to the sequencer
    always_comb begin
        o_sts.cfg_write  = cfg_hit;
        o_sts.rb_stop    = (r_i == sca_pkg::CLS_W'(NC - 1)) ||
                           (r_rbprod > sca_pkg::PROD_W'(sca_pkg::PAGE_BYTES * 256)) ||
                           (a_al > (sca_pkg::RS_W+1)'(sca_pkg::PAGE_BYTES));
        o_sts.div_done   = div_done;
        o_sts.hit        = (total != '0) && (total <= sca_pkg::TOT_W'(sz_c));
        o_sts.miss       = !o_sts.hit && ((total == '0) || (r_cls == r_largest) ||
                           (r_cls == sca_pkg::CLS_W'(NC - 1)));
        o_sts.is_free    = r_kind;
        o_sts.cnt_nz     = (r_cnt[r_cls] != '0);
        o_sts.cur_valid  = r_cvalid[r_cls];
        o_sts.stk_nz     = (r_top != '0);
        o_sts.fresh_ok   = (r_fresh < sca_pkg::PGC_W'(NP));
        o_sts.addr_low   = (r_uaddr < sca_pkg::ADDR_W'(r_hdr));
        o_sts.free_bad   = r_oob || !r_owned[r_page] || (pg_owner != r_cls) ||
                           (div_r != '0) ||
                           (div_q >= sca_pkg::DIV_W'(r_per_tab[r_cls])) ||
                           (r_cvalid[r_cls] && (r_cpage[r_cls] == r_page) &&
                            (div_q >= sca_pkg::DIV_W'(r_cnext[r_cls]))) ||
                           (r_cnt[r_cls] == sca_pkg::COUNT_MAX);
        o_sts.page_empty = (pg_used <= sca_pkg::USED_W'(1));
        o_sts.walk_last  = ((r_k + sca_pkg::CNT_W'(1)) == r_n);
        o_sts.out_busy   = o_valid && i_stall;
    end

    // memory ports
    always_comb begin
        link_ra = (i_cmd.step == sca_pkg::S_A_SEL) ? r_head[r_cls] : r_cur;
        link_we = 1'b0;
        link_wa = r_prev;
        link_wd = r_cur;
        if (i_cmd.step == sca_pkg::S_F_PUSH) begin
            link_we = 1'b1;
            link_wa = {r_page, r_idx};
            link_wd = r_head[r_cls];
        end else if (i_cmd.step == sca_pkg::S_P_ST) begin
            link_we = r_have_prev && (r_cur[sca_pkg::ID_W-1:sca_pkg::IDX_W] != r_page);
        end
        pg_we = 1'b0;
        pg_wa = r_page;
        pg_wd = {pg_owner, pg_used + sca_pkg::USED_W'(1)};
        unique case (i_cmd.step)
            sca_pkg::S_A_CLAIM: begin
                pg_we = 1'b1;
                pg_wa = r_np;
                pg_wd = {r_cls, sca_pkg::USED_W'(0)};
            end
            sca_pkg::S_A_USE_WR: pg_we = 1'b1;
            sca_pkg::S_F_PUSH: begin
                pg_we = 1'b1;
                pg_wd = {pg_owner, used_dec};
            end
            default: pg_we = 1'b0;
        endcase
        stk_ra = PGW'(r_top - sca_pkg::PGC_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            pg_mem[pg_wa] <= pg_wd;
        end
        r_pg_rd <= pg_mem[r_page];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == sca_pkg::S_P_END && r_top < sca_pkg::PGC_W'(NP)) begin
            stk_mem[r_top[PGW-1:0]] <= r_page;
        end
        r_stk_rd <= stk_mem[stk_ra];
    end

    // configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pay   <= sca_pkg::PAYLOAD_RESET;
            r_hdr   <= sca_pkg::HEADER_RESET;
            r_gf    <= sca_pkg::GROWTH_RESET;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sca_pkg::CFG_CHUNK_PAYLOAD: r_pay <= i_cfg_data;
                    sca_pkg::CFG_HEADER:        r_hdr <= i_cfg_data[sca_pkg::HDR_W-1:0];
                    sca_pkg::CFG_GROWTH:        r_gf  <= i_cfg_data[sca_pkg::GF_W-1:0];
                    default:                    r_pay <= r_pay;
                endcase
            end
            if (i_cmd.out_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status         <= r_status;
            o_result_address <= r_addr;
            o_class_index    <= r_cls;
            o_page_released  <= r_rel;
        end
    end

    // datapath state
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            sca_pkg::S_RB_INIT: begin
                r_size <= sca_pkg::RS_W'(r_hdr) + sca_pkg::RS_W'(r_pay);
                r_i    <= '0;
                r_top  <= '0;
                r_fresh <= '0;
                for (int c = 0; c < NC; c++) begin
                    r_head[c]   <= '0;
                    r_cnt[c]    <= '0;
                    r_cvalid[c] <= 1'b0;
                    r_cpage[c]  <= '0;
                    r_cnext[c]  <= '0;
                    r_cleft[c]  <= '0;
                end
                for (int p = 0; p < NP; p++) begin
                    r_owned[p] <= 1'b0;
                end
            end
            sca_pkg::S_RB_MUL: r_rbprod <= r_size * r_gf;
            sca_pkg::S_RB_DIV: begin
                if (div_done) begin
                    r_size_tab[r_i] <= a_al[sca_pkg::SIZE_W-1:0];
                    r_per_tab[r_i]  <= (div_q > sca_pkg::DIV_W'(sca_pkg::CHUNKS_PER_PAGE_MAX)) ?
                                       sca_pkg::PER_W'(sca_pkg::CHUNKS_PER_PAGE_MAX) :
                                       div_q[sca_pkg::PER_W-1:0];
                    r_size <= next_size[sca_pkg::SIZE_W+sca_pkg::GF_W-1:8];
                    r_i    <= r_i + sca_pkg::CLS_W'(1);
                end
            end
            sca_pkg::S_RB_END: begin
                r_largest       <= r_i;
                r_size_tab[r_i] <= sca_pkg::SIZE_W'(sca_pkg::PAGE_BYTES);
                r_per_tab[r_i]  <= sca_pkg::PER_W'(1);
            end
            sca_pkg::S_IDLE: begin
                if (i_cmd.accept) begin
                    r_kind   <= i_kind;
                    r_req    <= i_request_bytes;
                    r_uaddr  <= i_user_address;
                    r_cls    <= '0;
                    r_status <= sca_pkg::ST_OK;
                    r_addr   <= '0;
                    r_rel    <= 1'b0;
                end
            end
            sca_pkg::S_SRCH: begin
                if (o_sts.miss) begin
                    r_cls    <= '0;
                    r_status <= r_kind ? sca_pkg::ST_BAD_FREE : sca_pkg::ST_NO_CLASS;
                end else if (!o_sts.hit) begin
                    r_cls <= r_cls + sca_pkg::CLS_W'(1);
                end
            end
            sca_pkg::S_A_SEL: begin
                priority if (o_sts.cnt_nz || o_sts.cur_valid) begin
                    r_np <= r_np;
                end else if (o_sts.stk_nz) begin
                    r_top <= r_top - sca_pkg::PGC_W'(1);
                end else if (o_sts.fresh_ok) begin
                    r_np    <= r_fresh[PGW-1:0];
                    r_fresh <= r_fresh + sca_pkg::PGC_W'(1);
                end else begin
                    r_status <= sca_pkg::ST_EXHAUSTED;
                end
            end
            sca_pkg::S_A_POP: begin
                r_head[r_cls] <= r_link_rd;
                r_cnt[r_cls]  <= r_cnt[r_cls] - sca_pkg::CNT_W'(1);
                r_page        <= r_head[r_cls][sca_pkg::ID_W-1:sca_pkg::IDX_W];
                r_idx         <= r_head[r_cls][sca_pkg::IDX_W-1:0];
            end
            sca_pkg::S_A_STK: r_np <= r_stk_rd;
            sca_pkg::S_A_CLAIM: begin
                r_owned[r_np]   <= 1'b1;
                r_cpage[r_cls]  <= r_np;
                r_cvalid[r_cls] <= 1'b1;
                r_cnext[r_cls]  <= '0;
                r_cleft[r_cls]  <= r_per_tab[r_cls];
            end
            sca_pkg::S_A_CARVE: begin
                r_page         <= r_cpage[r_cls];
                r_idx          <= r_cnext[r_cls][sca_pkg::IDX_W-1:0];
                r_cleft[r_cls] <= left_dec;
                if (left_dec == '0) begin
                    r_cvalid[r_cls] <= 1'b0;
                    r_cnext[r_cls]  <= '0;
                end else begin
                    r_cnext[r_cls] <= r_cnext[r_cls] + sca_pkg::PER_W'(1);
                end
            end
            sca_pkg::S_A_USE_WR: r_aprod <= r_idx * sz_c;
            sca_pkg::S_A_ADDR: begin
                r_addr <= {r_page, sca_pkg::PAGE_W'(0)} + r_aprod[sca_pkg::ADDR_W-1:0] +
                          sca_pkg::ADDR_W'(r_hdr);
            end
            sca_pkg::S_F_CHK0: begin
                if (o_sts.addr_low) begin
                    r_status <= sca_pkg::ST_BAD_FREE;
                end else begin
                    r_page <= ua_page[PGW-1:0];
                    r_oob  <= (32'(ua_page) >= NP);
                end
            end
            sca_pkg::S_F_CHK1: begin
                r_idx <= div_q[sca_pkg::IDX_W-1:0];
                if (o_sts.free_bad) begin
                    r_status <= sca_pkg::ST_BAD_FREE;
                end
            end
            sca_pkg::S_F_PUSH: begin
                r_head[r_cls] <= {r_page, r_idx};
                r_cnt[r_cls]  <= r_cnt[r_cls] + sca_pkg::CNT_W'(1);
            end
            sca_pkg::S_P_INIT: begin
                r_cur       <= r_head[r_cls];
                r_n         <= r_cnt[r_cls];
                r_k         <= '0;
                r_kept      <= '0;
                r_have_prev <= 1'b0;
                r_new_head  <= '0;
            end
            sca_pkg::S_P_ST: begin
                // keep chunks of other pages, relinking behind the last kept one
                if (r_cur[sca_pkg::ID_W-1:sca_pkg::IDX_W] != r_page) begin
                    if (!r_have_prev) begin
                        r_new_head <= r_cur;
                    end
                    r_prev      <= r_cur;
                    r_have_prev <= 1'b1;
                    r_kept      <= r_kept + sca_pkg::CNT_W'(1);
                end
                r_cur <= r_link_rd;
                r_k   <= r_k + sca_pkg::CNT_W'(1);
            end
            sca_pkg::S_P_END: begin
                r_head[r_cls] <= r_new_head;
                r_cnt[r_cls]  <= r_kept;
                if (r_cvalid[r_cls] && r_cpage[r_cls] == r_page) begin
                    r_cvalid[r_cls] <= 1'b0;
                    r_cnext[r_cls]  <= '0;
                    r_cleft[r_cls]  <= '0;
                end
                r_owned[r_page] <= 1'b0;
                if (r_top < sca_pkg::PGC_W'(NP)) begin
                    r_top <= r_top + sca_pkg::PGC_W'(1);
                end
                r_rel <= 1'b1;
            end
            default: r_rel <= r_rel;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(o_valid && i_stall))
        else $error("result loaded over a pending transaction");
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != sca_pkg::ST_OK) |-> (o_result_address == '0))
        else $error("failed transaction carries an address");
    a_rel_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_page_released) |-> (o_status == sca_pkg::ST_OK))
        else $error("page released on a failed transaction");
    a_top_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == sca_pkg::S_IDLE) |-> (r_top <= sca_pkg::PGC_W'(NP) &&
                                             r_fresh <= sca_pkg::PGC_W'(NP)))
        else $error("page stack or fresh counter out of range");
`endif

endmodule
